@@ rtl/tspr_pkg.sv @@
// ----------------------------------------------------------------------------
// tspr_pkg
// Shared types and constants for the tile and sprite pixel renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tspr_pkg;

  // Item and result field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 9;

  // Memory geometry
  localparam int NT_DEPTH       = 1024;
  localparam int NT_AW          = 10;
  localparam int PAL_DEPTH      = 32;
  localparam int PAL_AW         = 5;
  localparam int PAT_HALF_DEPTH = 4096;
  localparam int PAT_HALF_AW    = 12;
  localparam int SPR_MAX_DEPTH  = 256;

  // Screen constants
  localparam logic [ADDR_W-1:0] TILE_COUNT = 13'd960;
  localparam logic [NT_AW-1:0]  ATTR_BASE  = 10'h3c0;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_BANK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPR_BANK = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WR_NT      = 3'd0,
    OP_WR_PAL     = 3'd1,
    OP_WR_PAT     = 3'd2,
    OP_WR_SPR     = 3'd3,
    OP_DRAW_TILE  = 3'd4,
    OP_DRAW_SPR   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_FETCH,
    ST_PIX,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       start;   // draw item taken: latch number, clear counters
    logic       write;   // item taken: perform any memory write
    logic       hdr;     // header fetch step active
    logic [2:0] step;    // header step
    logic       fetch;   // read pattern row
    logic       pix;     // scan one pixel
    logic       flush;   // push the held pixel as the last one
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stall;       // current pixel must wait for the output slot
    logic row_end;     // column counter at the last column
    logic last_row;    // row counter at the last row
    logic pend_valid;  // a pixel is held back
    logic out_free;    // output register can take a pixel this cycle
  } stat_t;

endpackage

@@ rtl/tspr_item_if.sv @@
// ----------------------------------------------------------------------------
// tspr_item_if
// Input item channel: valid/ready with opcode, address and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tspr_item_if
  import tspr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output opcode, output address, output data, input ready);
  modport sink (input valid, input opcode, input address, input data, output ready);
endinterface

@@ rtl/tspr_pixel_if.sv @@
// ----------------------------------------------------------------------------
// tspr_pixel_if
// Result channel: valid/ready with one emitted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tspr_pixel_if
  import tspr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [BYTE_W-1:0]  color_index;
  logic               last;

  modport source (output valid, output pixel_x, output pixel_y, output color_index,
                  output last, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input color_index,
                input last, output ready);
endinterface

@@ rtl/tspr_ram.sv @@
// ----------------------------------------------------------------------------
// tspr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tspr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tspr_ctrl
// Sequencer: header fetch, per-row pattern fetch, pixel scan and final flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tspr_ctrl
  import tspr_pkg::*;
#(
  parameter int SPRITE_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [OP_W-1:0]   item_opcode,
  input  logic [ADDR_W-1:0] item_address,
  output logic              item_ready,
  input  stat_t             stat,
  output cmd_t              cmd
);

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic       xfer;
  logic       draw_ok;

  assign item_ready = (state == ST_IDLE);
  assign xfer       = item_valid && item_ready;

  // Decide whether a taken item starts a draw
  always_comb begin
    draw_ok = 1'b0;
    if (item_opcode == OP_DRAW_TILE) begin
      draw_ok = (item_address < TILE_COUNT);
    end else if (item_opcode == OP_DRAW_SPR) begin
      draw_ok = (item_address < ADDR_W'(SPRITE_COUNT));
    end
  end

  // State and header step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      ST_IDLE: begin
        cmd.write = xfer;
        if (xfer && draw_ok) begin
          cmd.start  = 1'b1;
          step_next  = '0;
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        cmd.hdr   = 1'b1;
        step_next = step + 3'd1;
        if (step == 3'd7) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_PIX;
      end
      ST_PIX: begin
        cmd.pix = 1'b1;
        if (!stat.stall && stat.row_end) begin
          state_next = stat.last_row ? ST_FLUSH : ST_FETCH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!stat.pend_valid || stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tspr_dp.sv @@
// ----------------------------------------------------------------------------
// tspr_dp
// Datapath: memories, bank registers, header registers, pixel counters,
// held pixel and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tspr_dp
  import tspr_pkg::*;
#(
  parameter int SPRITE_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic [OP_W-1:0]      item_opcode,
  input  logic [ADDR_W-1:0]    item_address,
  input  logic [BYTE_W-1:0]    item_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  tspr_pixel_if.source         pixel
);

  localparam int SPR_DEPTH = 4 * SPRITE_COUNT;
  localparam int SPR_AW    = $clog2(SPR_DEPTH);

  // Configuration
  logic bg_bank, spr_bank;

  // Header registers
  logic [NT_AW-1:0]  num;
  logic              is_sprite;
  logic [BYTE_W-1:0] tile;
  logic [1:0]        pal_p;
  logic              vflip, hflip;
  logic [BYTE_W-1:0] sx, sy;
  logic [BYTE_W-1:0] c0, c1, c2, c3;
  logic [2:0]        dx, dy;

  // Held pixel and output register
  logic               pend_valid;
  logic [COORD_W-1:0] pend_x, pend_y;
  logic [BYTE_W-1:0]  pend_c;
  logic               out_valid, out_last;
  logic [COORD_W-1:0] out_x, out_y;
  logic [BYTE_W-1:0]  out_c;

  // Memory ports
  logic                   nt_we, pal_we, pat_lo_we, pat_hi_we, spr_we;
  logic [NT_AW-1:0]       nt_raddr;
  logic [PAL_AW-1:0]      pal_raddr;
  logic [PAT_HALF_AW-1:0] pat_waddr, pat_raddr;
  logic [SPR_AW-1:0]      spr_raddr;
  logic [BYTE_W-1:0]      nt_q, pal_q, pat_lo_q, pat_hi_q, spr_q;

  // Pixel evaluation
  logic [2:0]         pcol, pbit, prow;
  logic [1:0]         v;
  logic               opaque;
  logic [BYTE_W-1:0]  color;
  logic [COORD_W-1:0] x_cur, y_cur;
  logic               advance, load_out;
  logic [2:0]         attr_sh;

  // Bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_bank  <= 1'b0;
      spr_bank <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BG_BANK:  bg_bank  <= cfg_data;
        REG_SPR_BANK: spr_bank <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode write items
  always_comb begin
    nt_we     = 1'b0;
    pal_we    = 1'b0;
    pat_lo_we = 1'b0;
    pat_hi_we = 1'b0;
    spr_we    = 1'b0;
    if (cmd.write) begin
      unique case (item_opcode)
        OP_WR_NT:  nt_we = 1'b1;
        OP_WR_PAL: pal_we = 1'b1;
        OP_WR_PAT: begin
          pat_lo_we = !item_address[3];
          pat_hi_we = item_address[3];
        end
        OP_WR_SPR: spr_we = ({1'b0, item_address[7:0]} < 9'(SPR_DEPTH));
        default: ;
      endcase
    end
  end

  // Pattern bytes split by plane: address bit 3 picks the plane
  assign pat_waddr = {item_address[12:4], item_address[2:0]};

  // Header read addresses
  assign nt_raddr  = (cmd.step == 3'd0) ? num : ATTR_BASE + NT_AW'({num[9:7], num[4:2]});
  assign spr_raddr = SPR_AW'({num[5:0], cmd.step[1:0]});
  assign pal_raddr = (cmd.step == 3'd3) ? '0 :
                     {is_sprite, pal_p, 2'(cmd.step - 3'd3)};

  // Pattern row address
  assign prow      = dy ^ {3{vflip}};
  assign pat_raddr = {(is_sprite ? spr_bank : bg_bank), tile, prow};

  tspr_ram #(.WIDTH(BYTE_W), .DEPTH(NT_DEPTH)) u_nt (
    .clk(clk), .we(nt_we), .waddr(item_address[NT_AW-1:0]), .wdata(item_data),
    .re(cmd.hdr), .raddr(nt_raddr), .rdata(nt_q)
  );

  tspr_ram #(.WIDTH(BYTE_W), .DEPTH(PAL_DEPTH)) u_pal (
    .clk(clk), .we(pal_we), .waddr(item_address[PAL_AW-1:0]), .wdata(item_data),
    .re(cmd.hdr), .raddr(pal_raddr), .rdata(pal_q)
  );

  tspr_ram #(.WIDTH(BYTE_W), .DEPTH(PAT_HALF_DEPTH)) u_pat_lo (
    .clk(clk), .we(pat_lo_we), .waddr(pat_waddr), .wdata(item_data),
    .re(cmd.fetch), .raddr(pat_raddr), .rdata(pat_lo_q)
  );

  tspr_ram #(.WIDTH(BYTE_W), .DEPTH(PAT_HALF_DEPTH)) u_pat_hi (
    .clk(clk), .we(pat_hi_we), .waddr(pat_waddr), .wdata(item_data),
    .re(cmd.fetch), .raddr(pat_raddr), .rdata(pat_hi_q)
  );

  tspr_ram #(.WIDTH(BYTE_W), .DEPTH(SPR_DEPTH)) u_spr (
    .clk(clk), .we(spr_we), .waddr(item_address[SPR_AW-1:0]), .wdata(item_data),
    .re(cmd.hdr), .raddr(spr_raddr), .rdata(spr_q)
  );

  // Attribute quadrant shift: column bit 1 and row bit 1 of the tile
  assign attr_sh = {num[6], num[1], 1'b0};

  // Latch item and capture header bytes as they return
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num       <= item_address[NT_AW-1:0];
      is_sprite <= (item_opcode == OP_DRAW_SPR);
      vflip     <= 1'b0;
      hflip     <= 1'b0;
    end
    if (cmd.hdr) begin
      unique case (cmd.step)
        3'd1: begin
          if (is_sprite) sy <= spr_q;
          else tile <= nt_q;
        end
        3'd2: begin
          if (is_sprite) tile <= spr_q;
          else pal_p <= 2'(nt_q >> attr_sh);
        end
        3'd3: begin
          if (is_sprite) begin
            vflip <= spr_q[7];
            hflip <= spr_q[6];
            pal_p <= spr_q[1:0];
          end
        end
        3'd4: begin
          sx <= spr_q;
          c0 <= pal_q;
        end
        3'd5: c1 <= pal_q;
        3'd6: c2 <= pal_q;
        3'd7: c3 <= pal_q;
        default: ;
      endcase
    end
  end

  // Evaluate the current pixel from the fetched pattern row
  always_comb begin
    pcol   = dx ^ {3{hflip}};
    pbit   = ~pcol;
    v      = {pat_hi_q[pbit], pat_lo_q[pbit]};
    opaque = !is_sprite || (v != 2'd0);
    unique case (v)
      2'd0: color = c0;
      2'd1: color = c1;
      2'd2: color = c2;
      2'd3: color = c3;
      default: color = c0;
    endcase
    if (is_sprite) begin
      x_cur = {1'b0, sx} + COORD_W'(dx);
      y_cur = {1'b0, sy} + COORD_W'(dy);
    end else begin
      x_cur = {1'b0, num[4:0], dx};
      y_cur = {1'b0, num[9:5], dy};
    end
  end

  assign stat.out_free   = !out_valid || pixel.ready;
  assign stat.stall      = opaque && pend_valid && !stat.out_free;
  assign stat.row_end    = (dx == 3'd7);
  assign stat.last_row   = (dy == 3'd7);
  assign stat.pend_valid = pend_valid;

  assign advance  = cmd.pix && !stat.stall;
  assign load_out = (advance && opaque && pend_valid) ||
                    (cmd.flush && pend_valid && stat.out_free);

  // Scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      dx <= '0;
      dy <= '0;
    end else if (cmd.start) begin
      dx <= '0;
      dy <= '0;
    end else if (advance) begin
      dx <= dx + 3'd1;
      if (dx == 3'd7) begin
        dy <= dy + 3'd1;
      end
    end
  end

  // Hold one pixel back so the final one can carry the last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance && opaque) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush && stat.out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && opaque) begin
      pend_x <= x_cur;
      pend_y <= y_cur;
      pend_c <= color;
    end
  end

  // Output register: load the held pixel, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_c    <= pend_c;
      out_last <= cmd.flush;
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_x     = out_x;
  assign pixel.pixel_y     = out_y;
  assign pixel.color_index = out_c;
  assign pixel.last        = out_last;

endmodule

@@ rtl/tile_sprite_pixel_renderer.sv @@
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer
// Write items are performed when taken, and configuration writes when cfg_we is high. A
// draw item runs a header fetch, then per row a pattern fetch and a pixel scan,
// then a flush of the held pixel. The pattern row fetch and the
// one-pixel-per-cycle scan, which stalls while the output slot is busy, set
// the draw time. Synchronous reset clears the sequencer, output and bank
// registers; the memories are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_sprite_pixel_renderer
  import tspr_pkg::*;
#(
  parameter int SPRITE_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  tspr_item_if.sink            item,
  tspr_pixel_if.source         pixel
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  tspr_ctrl #(.SPRITE_COUNT(SPRITE_COUNT)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_opcode  (item.opcode),
    .item_address (item.address),
    .item_ready   (item.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Memories and pixel datapath
  tspr_dp #(.SPRITE_COUNT(SPRITE_COUNT)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_opcode  (item.opcode),
    .item_address (item.address),
    .item_data    (item.data),
    .cmd          (cmd),
    .stat         (stat),
    .pixel        (pixel)
  );

`ifndef SYNTH
  // No pixel is held back while new items are taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !stat.pend_valid)
    else $error("held pixel while accepting items");

  // A row fetch is always followed by the pixel scan
  a_fetch_then_pix: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> cmd.pix)
    else $error("pattern fetch not followed by scan");

  // Flush with a free output slot empties the held pixel
  a_flush_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush && stat.out_free) |=> !stat.pend_valid)
    else $error("flush did not drain held pixel");
`endif

endmodule
